/* sv/sstp_pkg.sv */
// shared types, codes and the fixed palette of the screen decoder
`default_nettype none
package sstp_pkg;

	// field widths
	localparam int ADDR_W  = 14;
	localparam int DATA_W  = 8;
	localparam int SUM_W   = 15;
	localparam int EXT_W   = 18;
	localparam int COL_W   = 5;
	localparam int LINE_W  = 8;
	localparam int PIX_W   = 3;
	localparam int CIDX_W  = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [LINE_W-1:0]  LAST_LINE = 8'd191;
	localparam logic [COL_W-1:0]   LAST_COL  = 5'd31;
	localparam logic [PIX_W-1:0]   LAST_PIX  = 3'd7;
	localparam logic [ADDR_W-1:0]  ATTRIB_BASE_RST = 14'h1800;

	// input item kinds
	typedef enum logic {
		MODE_WRITE  = 1'b0,
		MODE_RENDER = 1'b1
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_BASE = 1'b0,
		REG_ATTRIB_BASE = 1'b1
	} cfg_reg_t;

	// one fetched 8-pixel group waiting for the serializer
	typedef struct packed {
		logic [DATA_W-1:0] pix;
		logic [DATA_W-1:0] attr;
		logic              flash;
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] line;
	} render_job_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// index bit 3 bright, bits 2..0 green red blue
	function automatic rgb_t palette(input logic [CIDX_W-1:0] idx);
		rgb_t c;
		begin
			case (idx)
				4'd0:  c = '{8'h00, 8'h00, 8'h00};
				4'd1:  c = '{8'h00, 8'h00, 8'hc0};
				4'd2:  c = '{8'hc0, 8'h00, 8'h00};
				4'd3:  c = '{8'hc0, 8'h00, 8'hc0};
				4'd4:  c = '{8'h00, 8'hc0, 8'h00};
				4'd5:  c = '{8'h00, 8'hc0, 8'hc0};
				4'd6:  c = '{8'hc0, 8'hc0, 8'h00};
				4'd7:  c = '{8'hd0, 8'hd0, 8'hd0};
				4'd8:  c = '{8'h00, 8'h00, 8'h00};
				4'd9:  c = '{8'h00, 8'h00, 8'hff};
				4'd10: c = '{8'hff, 8'h00, 8'h00};
				4'd11: c = '{8'hff, 8'h00, 8'hff};
				4'd12: c = '{8'h00, 8'hff, 8'h00};
				4'd13: c = '{8'h00, 8'hff, 8'hff};
				4'd14: c = '{8'hff, 8'hff, 8'h00};
				default: c = '{8'hff, 8'hff, 8'hff};
			endcase
			return c;
		end
	endfunction

endpackage
`default_nettype wire

/* sv/sstp_if.sv */
// channel interfaces: input items, pixel results, configuration writes
`default_nettype none
interface sstp_in_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [sstp_pkg::ADDR_W-1:0]    address;
	logic [sstp_pkg::DATA_W-1:0]    data;
	logic                           flash_on;

	modport source (output valid, mode, address, data, flash_on, input ready);
	modport sink   (input valid, mode, address, data, flash_on, output ready);
endinterface

interface sstp_out_if;
	logic                           valid;
	logic                           ready;
	logic [sstp_pkg::CIDX_W-1:0]    color_index;
	logic [7:0]                     red;
	logic [7:0]                     green;
	logic [7:0]                     blue;
	logic [7:0]                     pixel_x;
	logic [sstp_pkg::LINE_W-1:0]    pixel_y;
	logic                           last;

	modport source (output valid, color_index, red, green, blue, pixel_x, pixel_y, last,
		input ready);
	modport sink   (input valid, color_index, red, green, blue, pixel_x, pixel_y, last,
		output ready);
endinterface

interface sstp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sstp_pkg::CFG_IDX_W-1:0]   index;
	logic [sstp_pkg::ADDR_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/sstp_front.sv */
// front end: config registers, video memory, scan position and group fetch
`default_nettype none
module sstp_front #(
	parameter int MEM_DEPTH = 16384,
	parameter int QDEPTH    = 4,
	parameter int LVL_W     = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	sstp_in_if.sink                    in_ch,
	sstp_cfg_if.sink                   cfg,
	input  wire logic [LVL_W-1:0]      q_level,
	output logic                       push,
	output sstp_pkg::render_job_t      push_job
);
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [sstp_pkg::EXT_W-1:0] DEP1 = sstp_pkg::EXT_W'(MEM_DEPTH);
	localparam logic [sstp_pkg::EXT_W-1:0] DEP2 = sstp_pkg::EXT_W'(2 * MEM_DEPTH);

	// reduce a sum below three times the depth modulo the depth
	function automatic logic [AW-1:0] wrap(input logic [sstp_pkg::EXT_W-1:0] v);
		logic [sstp_pkg::EXT_W-1:0] r;
		begin
			if (v >= DEP2) begin
				r = v - DEP2;
			end else if (v >= DEP1) begin
				r = v - DEP1;
			end else begin
				r = v;
			end
			return r[AW-1:0];
		end
	endfunction

	logic [sstp_pkg::ADDR_W-1:0]  screen_base_q;
	logic [sstp_pkg::ADDR_W-1:0]  attrib_base_q;
	logic [sstp_pkg::LINE_W-1:0]  line_q;
	logic [sstp_pkg::COL_W-1:0]   col_q;
	logic [sstp_pkg::DATA_W-1:0]  mem_q [MEM_DEPTH];

	logic                         valid_s1;
	logic [sstp_pkg::DATA_W-1:0]  pix_s1;
	logic [sstp_pkg::DATA_W-1:0]  attr_s1;
	logic                         flash_s1;
	logic [sstp_pkg::COL_W-1:0]   col_s1;
	logic [sstp_pkg::LINE_W-1:0]  line_s1;

	logic                         acc;
	logic                         wr_en;
	logic                         rd_en;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                pix_addr;
	logic [AW-1:0]                attr_addr;
	logic [sstp_pkg::SUM_W-1:0]   pix_sum;
	logic [sstp_pkg::SUM_W-1:0]   attr_sum;
	logic [LVL_W:0]               used;

	// room for the group in flight plus the new one
	assign used        = {1'b0, q_level} + (LVL_W+1)'(valid_s1);
	assign in_ch.ready = used < (LVL_W+1)'(QDEPTH);
	assign cfg.ready   = 1'b1;

	assign acc   = in_ch.valid && in_ch.ready;
	assign wr_en = acc && (in_ch.mode == sstp_pkg::MODE_WRITE);
	assign rd_en = acc && (in_ch.mode == sstp_pkg::MODE_RENDER);

	// line bits map as {y7:6, y2:0, y5:3, column}
	assign pix_sum  = sstp_pkg::SUM_W'(screen_base_q)
		+ sstp_pkg::SUM_W'({line_q[7:6], line_q[2:0], line_q[5:3], col_q});
	assign attr_sum = sstp_pkg::SUM_W'(attrib_base_q)
		+ sstp_pkg::SUM_W'({line_q[7:3], col_q});

	assign wr_addr   = wrap(sstp_pkg::EXT_W'(in_ch.address));
	assign pix_addr  = wrap(sstp_pkg::EXT_W'(pix_sum));
	assign attr_addr = wrap(sstp_pkg::EXT_W'(attr_sum));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_base_q <= '0;
			attrib_base_q <= sstp_pkg::ATTRIB_BASE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				sstp_pkg::REG_SCREEN_BASE: screen_base_q <= cfg.data;
				sstp_pkg::REG_ATTRIB_BASE: attrib_base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (rd_en) begin
				if (col_q == sstp_pkg::LAST_COL) begin
					col_q  <= '0;
					line_q <= (line_q == sstp_pkg::LAST_LINE) ? '0 : line_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// video memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= in_ch.data;
		end
		if (rd_en) begin
			pix_s1   <= mem_q[pix_addr];
			attr_s1  <= mem_q[attr_addr];
			flash_s1 <= in_ch.flash_on;
			col_s1   <= col_q;
			line_s1  <= line_q;
		end
	end

	assign push          = valid_s1;
	assign push_job.pix  = pix_s1;
	assign push_job.attr = attr_s1;
	assign push_job.flash = flash_s1;
	assign push_job.col  = col_s1;
	assign push_job.line = line_s1;

endmodule
`default_nettype wire

/* sv/sstp_queue.sv */
// short queue of fetched groups between front and back
`default_nettype none
module sstp_queue #(
	parameter int DEPTH = 4,
	parameter int LVL_W = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire sstp_pkg::render_job_t push_job,
	input  wire logic                  pop,
	output logic                       q_valid,
	output sstp_pkg::render_job_t      q_job,
	output logic [LVL_W-1:0]           level
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

	sstp_pkg::render_job_t  slot_q [DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [LVL_W-1:0]       count_q;
	logic                   do_pop;

	assign q_valid = count_q != '0;
	assign q_job   = slot_q[rd_ptr_q];
	assign level   = count_q;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/sstp_back.sv */
// back end: attribute decode and one pixel per cycle into the output register while out_ch is ready
`default_nettype none
module sstp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire sstp_pkg::render_job_t q_job,
	output logic                       pop,
	sstp_out_if.source                 out_ch
);
	sstp_pkg::render_job_t          job_q;
	logic                           busy_q;
	logic [sstp_pkg::PIX_W-1:0]     pix_q;
	logic                           ovalid_q;
	logic [sstp_pkg::CIDX_W-1:0]    cidx_q;
	sstp_pkg::rgb_t                 rgb_q;
	logic [7:0]                     x_q;
	logic [sstp_pkg::LINE_W-1:0]    y_q;
	logic                           last_q;

	logic                           adv;
	logic                           emit;
	logic                           finish;
	logic                           swap;
	logic [sstp_pkg::CIDX_W-1:0]    ink;
	logic [sstp_pkg::CIDX_W-1:0]    paper;
	logic [sstp_pkg::CIDX_W-1:0]    cidx;

	assign adv    = !ovalid_q || out_ch.ready;
	assign emit   = adv && busy_q;
	assign finish = emit && (pix_q == sstp_pkg::LAST_PIX);
	assign pop    = q_valid && (!busy_q || finish);

	always_comb begin
		swap  = job_q.attr[7] && job_q.flash;
		ink   = {job_q.attr[6], job_q.attr[2:0]};
		paper = job_q.attr[6:3];
		if (job_q.pix[sstp_pkg::LAST_PIX - pix_q] != swap) begin
			cidx = ink;
		end else begin
			cidx = paper;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pix_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pix_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				pix_q <= pix_q + 1'b1;
			end
			if (adv) begin
				ovalid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			cidx_q <= cidx;
			rgb_q  <= sstp_pkg::palette(cidx);
			x_q    <= {job_q.col, pix_q};
			y_q    <= job_q.line;
			last_q <= pix_q == sstp_pkg::LAST_PIX;
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.color_index = cidx_q;
	assign out_ch.red         = rgb_q.r;
	assign out_ch.green       = rgb_q.g;
	assign out_ch.blue        = rgb_q.b;
	assign out_ch.pixel_x     = x_q;
	assign out_ch.pixel_y     = y_q;
	assign out_ch.last        = last_q;

endmodule
`default_nettype wire

/* sv/spectrum_screen_to_pixels.sv */
// top level of the screen-to-pixels decoder
// usage:
//   in_ch  : one transaction is a write (mode 0, stores data at address) or a
//            render (mode 1, fetches the next 8-pixel group of the raster)
//   out_ch : one transaction per pixel, eight per render, last on the eighth
//   cfg    : register writes (index 0 screen base, index 1 attribute base),
//            always ready, to be used while the block is idle
// throughput: a write is accepted whenever in_ch is ready; renders enter one per cycle
//   until the group queue is full, results leave at one pixel per cycle while
//   out_ch is ready, so the sustained render rate is set by the pixel serializer
// path: a render is read from memory at the accepting edge, then its first pixel
//   passes the queue, serializer and output register
// reset: scan position returns to line 0 column 0, bases to 0 and 0x1800,
//   queue and output empty; video memory holds whatever it held
// stall: when out_ch is not ready the output register holds, the serializer
//   stops, the queue fills and in_ch drops ready once no room is left
`default_nettype none
module spectrum_screen_to_pixels #(
	parameter int MEM_DEPTH = 16384
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sstp_in_if.sink     in_ch,
	sstp_out_if.source  out_ch,
	sstp_cfg_if.sink    cfg
);
	// queue of fetched groups, deep enough to cover the fetch stage
	localparam int QDEPTH = 4;
	localparam int LVL_W  = $clog2(QDEPTH + 1);

	logic                    push;
	sstp_pkg::render_job_t   push_job;
	logic                    pop;
	logic                    q_valid;
	sstp_pkg::render_job_t   q_job;
	logic [LVL_W-1:0]        q_level;

	// accepts transactions, owns memory and raster counters
	sstp_front #(
		.MEM_DEPTH (MEM_DEPTH),
		.QDEPTH    (QDEPTH),
		.LVL_W     (LVL_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.q_level  (q_level),
		.push     (push),
		.push_job (push_job)
	);

	// decouples the fetch from the pixel serializer
	sstp_queue #(
		.DEPTH (QDEPTH),
		.LVL_W (LVL_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.level    (q_level)
	);

	// ink/paper/flash decode, palette lookup and pixel output
	sstp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (q_job),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule
`default_nettype wire
